>>> hw/rtl/pps_pkg.sv
`timescale 1ns / 1ps
package pps_pkg;

  // cordic datapath and shared multiplier widths
  localparam int CW = 46;
  localparam int MW = 34;
  localparam int PW = 2 * MW;
  localparam int CSW = 27;
  localparam int SW = 5;

  localparam int ACT_W = 2;
  localparam int NEAR_W = 10;
  localparam int SPD_W = 16;
  localparam int STAT_W = 2;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam int Q_GAIN = 10188014;
  localparam int A_PI = 205887;
  localparam int A_HALF_PI = 102944;
  localparam int A_TWO_PI = 411775;

  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
  localparam logic [ACT_W-1:0] ACT_POSE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  localparam logic [STAT_W-1:0] ST_TRACK = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOFWD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WHEELBASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKAHEAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd2;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_req_t;

  // atan(2^-i) in q16 radians
  function automatic logic [16:0] atan_lut(input logic [SW-1:0] i);
    logic [16:0] v;
    case (i)
      5'd0: v = 17'd51472;
      5'd1: v = 17'd30386;
      5'd2: v = 17'd16055;
      5'd3: v = 17'd8150;
      5'd4: v = 17'd4091;
      5'd5: v = 17'd2047;
      5'd6: v = 17'd1024;
      5'd7: v = 17'd512;
      5'd8: v = 17'd256;
      5'd9: v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

endpackage

>>> hw/rtl/pps_if.sv
`timescale 1ns / 1ps
interface pps_in_if import pps_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16
);
  logic valid;
  logic ready;
  logic [ACT_W-1:0] action;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] pose_x;
  logic signed [COORD_BITS-1:0] pose_y;
  logic signed [ANGLE_BITS-1:0] heading;
  modport source(output valid, action, point_x, point_y, pose_x, pose_y, heading,
                 input ready);
  modport sink(input valid, action, point_x, point_y, pose_x, pose_y, heading,
               output ready);
endinterface

interface pps_out_if import pps_pkg::*; #(
  parameter int ANGLE_BITS = 16
);
  logic valid;
  logic ready;
  logic signed [ANGLE_BITS-1:0] steer_angle;
  logic [SPD_W-1:0] speed_cmd;
  logic [NEAR_W-1:0] near_index;
  logic [STAT_W-1:0] status;
  modport source(output valid, steer_angle, speed_cmd, near_index, status, input ready);
  modport sink(input valid, steer_angle, speed_cmd, near_index, status, output ready);
endinterface

>>> hw/rtl/pps_mul.sv
`timescale 1ns / 1ps
module pps_mul import pps_pkg::*; (
  input  logic                 clk,
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);
  logic signed [PW-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

  assign p = p_r;
endmodule

>>> hw/rtl/pps_cordic.sv
`timescale 1ns / 1ps
module pps_cordic import pps_pkg::*; #(
  parameter int ZW = 21,
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cordic_req_t          req,
  input  logic signed [CW-1:0] x0,
  input  logic signed [CW-1:0] y0,
  input  logic signed [ZW-1:0] z0,
  output logic                 done,
  output logic signed [CW-1:0] xo,
  output logic signed [CW-1:0] yo,
  output logic signed [ZW-1:0] zo
);
  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;

  localparam logic signed [ZW-1:0] ZPI = ZW'(A_PI);
  localparam logic signed [ZW-1:0] ZHP = ZW'(A_HALF_PI);
  localparam logic signed [ZW-1:0] Z2PI = ZW'(A_TWO_PI);

  logic [1:0] state_r;
  logic done_r, flip_r, vec_r;
  logic [SW-1:0] i_r;
  logic signed [CW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r, za;
  logic neg;

  assign xs = x_r >>> i_r;
  assign ys = y_r >>> i_r;
  assign za = $signed(ZW'(atan_lut(i_r)));
  assign neg = vec_r ? (y_r > 0) : (z_r < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (req.start) begin
            flip_r <= 1'b0;
            vec_r <= req.vec;
            i_r <= '0;
            if (req.vec) begin
              x_r <= x0;
              y_r <= y0;
              z_r <= '0;
              // zero y gives an exact zero angle
              if (y0 == '0) done_r <= 1'b1;
              else state_r <= C_ITER;
            end else begin
              x_r <= CW'(Q_GAIN);
              y_r <= '0;
              z_r <= z0;
              state_r <= C_RED;
            end
          end
        end
        C_RED: begin
          // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
          if (z_r > ZPI) z_r <= z_r - Z2PI;
          else if (z_r < -ZPI) z_r <= z_r + Z2PI;
          else begin
            if (z_r > ZHP) begin
              z_r <= z_r - ZPI;
              flip_r <= 1'b1;
            end else if (z_r < -ZHP) begin
              z_r <= z_r + ZPI;
              flip_r <= 1'b1;
            end
            state_r <= C_ITER;
          end
        end
        C_ITER: begin
          if (neg) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + za;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - za;
          end
          i_r <= i_r + SW'(1);
          if (i_r == SW'(STEPS - 1)) begin
            done_r <= 1'b1;
            state_r <= C_IDLE;
          end
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign xo = flip_r ? -x_r : x_r;
  assign yo = flip_r ? -y_r : y_r;
  assign zo = z_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> state_r == C_IDLE) else $error("cordic started while busy");
  a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(state_r) == C_ITER) || $past(req.start && req.vec))
    else $error("cordic done without a run");
  a_step_rng: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == C_ITER |-> i_r < SW'(STEPS)) else $error("cordic step out of range");
endmodule

>>> hw/rtl/pure_pursuit_steering.sv
`timescale 1ns / 1ps
// pure pursuit steering with an on-chip path store
// in_ch: action 0 appends (point_x, point_y), 1 clears the path, 2 computes from
//   (pose_x, pose_y, heading); 3 is dropped. append and clear give no item on
//   out_ch; a full store drops appends
// out_ch: one item per compute: steer_angle, speed_cmd, near_index, status
// cfg_we/cfg_idx/cfg_data: 0 wheelbase, 1 lookahead distance, 2 set speed
// a compute runs on one shared multiplier and one iterative cordic, one item
//   at a time: a nearest-point scan over the stored points, a forward scan
//   from the nearest point, and four cordic runs; an empty path skips the
//   scans and the cordic runs
// the path memory has one read port, so each scan reads one point per step
// in_ch.ready is high only between computes
// reset empties the path and loads the register defaults; the memory itself is
//   not cleared, only entries below the point count are read
// a finished result sits in the output register; while the receiver stalls
//   the next item is still taken, a compute waits at its end for the register
module pure_pursuit_steering import pps_pkg::*; #(
  parameter int PATH_DEPTH = 1024,
  parameter int COORD_BITS = 24,
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pps_in_if.sink               in_ch,
  pps_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_data
);
  localparam int IDX_W = $clog2(PATH_DEPTH);
  localparam int CNT_W = $clog2(PATH_DEPTH + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int LW = COORD_BITS + 4;
  localparam int ML = (LW > 33) ? LW : 33;
  localparam int ZW = (ANGLE_BITS + 5 > 21) ? ANGLE_BITS + 5 : 21;
  localparam logic signed [PW-1:0] RND = PW'(24'd8388608);
  localparam logic signed [ZW-1:0] ZFOUR = ZW'(4);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_P1RD = 5'd1;
  localparam logic [4:0] S_P1DX = 5'd2;
  localparam logic [4:0] S_P1DY = 5'd3;
  localparam logic [4:0] S_P1CMP = 5'd4;
  localparam logic [4:0] S_L2 = 5'd5;
  localparam logic [4:0] S_ANG = 5'd6;
  localparam logic [4:0] S_ANGW = 5'd7;
  localparam logic [4:0] S_B0 = 5'd8;
  localparam logic [4:0] S_B1 = 5'd9;
  localparam logic [4:0] S_B2 = 5'd10;
  localparam logic [4:0] S_B3 = 5'd11;
  localparam logic [4:0] S_B4 = 5'd12;
  localparam logic [4:0] S_B5 = 5'd13;
  localparam logic [4:0] S_B6 = 5'd14;
  localparam logic [4:0] S_AT1 = 5'd15;
  localparam logic [4:0] S_AT1W = 5'd16;
  localparam logic [4:0] S_SC = 5'd17;
  localparam logic [4:0] S_SCW = 5'd18;
  localparam logic [4:0] S_NUM = 5'd19;
  localparam logic [4:0] S_NUMC = 5'd20;
  localparam logic [4:0] S_DW = 5'd21;
  localparam logic [4:0] S_FIN = 5'd22;

  logic [4:0] fsm_r, fsm_nxt;
  logic [CFG_W-1:0] wheel_r, look_r, speed_r;
  logic [CNT_W-1:0] count_r, k_r, k_inc;
  logic [IDX_W-1:0] near_r, rd_addr;
  logic rd_en, in_acc, mem_we;

  logic signed [COORD_BITS-1:0] mem_e [PATH_DEPTH];
  logic signed [COORD_BITS-1:0] mem_n [PATH_DEPTH];
  logic signed [COORD_BITS-1:0] rd_e_r, rd_n_r, px_r, py_r;
  logic signed [ANGLE_BITS-1:0] heading_r, res_steer_r;
  logic [STAT_W-1:0] res_status_r;

  logic [63:0] best_r, l2_r, sq0_r, sq_val, sum2;
  logic sat_r, is_sq, sq_big, fwd, hit, last;
  logic signed [LW-1:0] sq_src, lx_r, ly_r;
  logic [LW-1:0] sq_mag;
  logic [ML-1:0] sq_mag_w;
  logic signed [DW-1:0] dx, dy;
  logic signed [CSW-1:0] c_r, s_r, sint_r;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod, acc_r, bsum_add, bsum_sub;
  logic signed [ZW-1:0] th_r;

  cordic_req_t cor_req;
  logic cor_done;
  logic signed [CW-1:0] cx0, cy0, cxo, cyo;
  logic signed [ZW-1:0] cz0, czo;

  logic out_valid_r;
  logic signed [ANGLE_BITS-1:0] out_steer_r;
  logic [SPD_W-1:0] out_speed_r;
  logic [NEAR_W-1:0] out_near_r;
  logic [STAT_W-1:0] out_status_r;

  pps_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  pps_cordic #(.ZW(ZW), .STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cor_req),
    .x0    (cx0),
    .y0    (cy0),
    .z0    (cz0),
    .done  (cor_done),
    .xo    (cxo),
    .yo    (cyo),
    .zo    (czo)
  );

  assign in_ch.ready = (fsm_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign mem_we = in_acc && (in_ch.action == ACT_APPEND) && (count_r < CNT_W'(PATH_DEPTH));

  assign dx = DW'(rd_e_r) - DW'(px_r);
  assign dy = DW'(rd_n_r) - DW'(py_r);
  assign sq_mag = sq_src[LW-1] ? LW'(-sq_src) : LW'(sq_src);
  assign sq_mag_w = ML'(sq_mag);
  assign sq_big = sq_mag_w > ML'(33'h0FFFFFFFF);
  assign sq_val = sat_r ? '1 : prod[63:0];
  assign sum2 = sat_add64(sq0_r, sq_val);
  assign bsum_add = acc_r + prod + RND;
  assign bsum_sub = acc_r - prod + RND;
  assign k_inc = k_r + CNT_W'(1);
  assign fwd = lx_r > 0;
  assign hit = fwd && (sum2 >= l2_r);
  assign last = (k_inc == count_r);

  always_comb begin
    fsm_nxt = fsm_r;
    is_sq = 1'b0;
    sq_src = '0;
    mul_a = '0;
    mul_b = '0;
    rd_en = 1'b0;
    rd_addr = '0;
    cor_req = '0;
    cx0 = '0;
    cy0 = '0;
    cz0 = '0;
    case (fsm_r)
      S_IDLE: begin
        if (in_acc && in_ch.action == ACT_POSE)
          fsm_nxt = (count_r == '0) ? S_FIN : S_P1RD;
      end
      S_P1RD: begin
        rd_en = 1'b1;
        rd_addr = k_r[IDX_W-1:0];
        fsm_nxt = S_P1DX;
      end
      S_P1DX: begin
        is_sq = 1'b1;
        sq_src = LW'(dx);
        fsm_nxt = S_P1DY;
      end
      S_P1DY: begin
        is_sq = 1'b1;
        sq_src = LW'(dy);
        fsm_nxt = S_P1CMP;
      end
      S_P1CMP: begin
        if (last) fsm_nxt = S_L2;
        else begin
          rd_en = 1'b1;
          rd_addr = k_inc[IDX_W-1:0];
          fsm_nxt = S_P1DX;
        end
      end
      S_L2: begin
        is_sq = 1'b1;
        sq_src = $signed(LW'(look_r));
        fsm_nxt = S_ANG;
      end
      S_ANG: begin
        cor_req.start = 1'b1;
        cz0 = ZW'(heading_r) <<< 3;
        fsm_nxt = S_ANGW;
      end
      S_ANGW: begin
        if (cor_done) begin
          rd_en = 1'b1;
          rd_addr = near_r;
          fsm_nxt = S_B0;
        end
      end
      S_B0: begin
        mul_a = MW'(c_r);
        mul_b = MW'(dx);
        fsm_nxt = S_B1;
      end
      S_B1: begin
        mul_a = MW'(s_r);
        mul_b = MW'(dy);
        fsm_nxt = S_B2;
      end
      S_B2: begin
        mul_a = MW'(c_r);
        mul_b = MW'(dy);
        fsm_nxt = S_B3;
      end
      S_B3: begin
        mul_a = MW'(s_r);
        mul_b = MW'(dx);
        fsm_nxt = S_B4;
      end
      S_B4: begin
        is_sq = 1'b1;
        sq_src = lx_r;
        fsm_nxt = S_B5;
      end
      S_B5: begin
        is_sq = 1'b1;
        sq_src = ly_r;
        fsm_nxt = S_B6;
      end
      S_B6: begin
        if (hit) fsm_nxt = S_AT1;
        // out of points: the last point was just transformed
        else if (last) fsm_nxt = fwd ? S_AT1 : S_FIN;
        else begin
          rd_en = 1'b1;
          rd_addr = k_inc[IDX_W-1:0];
          fsm_nxt = S_B0;
        end
      end
      S_AT1: begin
        cor_req.start = 1'b1;
        cor_req.vec = 1'b1;
        cx0 = CW'(lx_r);
        cy0 = CW'(ly_r);
        fsm_nxt = S_AT1W;
      end
      S_AT1W: if (cor_done) fsm_nxt = S_SC;
      S_SC: begin
        cor_req.start = 1'b1;
        cz0 = th_r;
        fsm_nxt = S_SCW;
      end
      S_SCW: if (cor_done) fsm_nxt = S_NUM;
      S_NUM: begin
        mul_a = MW'($signed({1'b0, wheel_r}));
        mul_b = MW'(sint_r);
        fsm_nxt = S_NUMC;
      end
      S_NUMC: begin
        cor_req.start = 1'b1;
        cor_req.vec = 1'b1;
        cx0 = CW'($signed({1'b0, look_r, 24'd0}));
        cy0 = CW'(prod <<< 1);
        fsm_nxt = S_DW;
      end
      S_DW: if (cor_done) fsm_nxt = S_FIN;
      S_FIN: if (!out_valid_r || out_ch.ready) fsm_nxt = S_IDLE;
      default: fsm_nxt = S_IDLE;
    endcase
    if (is_sq) begin
      mul_a = MW'($signed({1'b0, sq_mag_w[31:0]}));
      mul_b = MW'($signed({1'b0, sq_mag_w[31:0]}));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_e[count_r[IDX_W-1:0]] <= in_ch.point_x;
      mem_n[count_r[IDX_W-1:0]] <= in_ch.point_y;
    end
    if (rd_en) begin
      rd_e_r <= mem_e[rd_addr];
      rd_n_r <= mem_n[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= is_sq && sq_big;
    case (fsm_r)
      S_IDLE: begin
        if (in_acc && in_ch.action == ACT_POSE) begin
          px_r <= in_ch.pose_x;
          py_r <= in_ch.pose_y;
          heading_r <= in_ch.heading;
          k_r <= '0;
          near_r <= '0;
          res_steer_r <= '0;
          res_status_r <= (count_r == '0) ? ST_EMPTY : ST_TRACK;
        end
      end
      S_P1DY: sq0_r <= sq_val;
      S_P1CMP: begin
        // strict compare keeps the first minimum
        if (k_r == '0 || sum2 < best_r) begin
          best_r <= sum2;
          near_r <= k_r[IDX_W-1:0];
        end
        k_r <= k_inc;
      end
      S_ANG: l2_r <= sq_val;
      S_ANGW: begin
        if (cor_done) begin
          c_r <= CSW'(cxo);
          s_r <= CSW'(cyo);
          k_r <= CNT_W'(near_r);
        end
      end
      S_B1: acc_r <= prod;
      S_B2: lx_r <= LW'(bsum_add >>> 24);
      S_B3: acc_r <= prod;
      S_B4: ly_r <= LW'(bsum_sub >>> 24);
      S_B5: sq0_r <= sq_val;
      S_B6: begin
        if (!hit && !last) k_r <= k_inc;
        if (!hit && last && !fwd) res_status_r <= ST_NOFWD;
      end
      S_AT1W: if (cor_done) th_r <= czo;
      S_SCW: if (cor_done) sint_r <= CSW'(cyo);
      S_DW: if (cor_done) res_steer_r <= ANGLE_BITS'((czo + ZFOUR) >>> 3);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fsm_r == S_FIN && (!out_valid_r || out_ch.ready)) begin
      out_steer_r <= res_steer_r;
      out_speed_r <= (res_status_r == ST_TRACK) ? speed_r : '0;
      out_near_r <= NEAR_W'(near_r);
      out_status_r <= res_status_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r <= S_IDLE;
      count_r <= '0;
      wheel_r <= 16'd768;
      look_r <= 16'd1152;
      speed_r <= 16'd1500;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      if (mem_we) count_r <= count_r + CNT_W'(1);
      else if (in_acc && in_ch.action == ACT_CLEAR) count_r <= '0;
      if (cfg_we) begin
        case (cfg_idx)
          REG_WHEELBASE: wheel_r <= cfg_data;
          REG_LOOKAHEAD: look_r <= cfg_data;
          REG_SPEED: speed_r <= cfg_data;
          default: ;
        endcase
      end
      if (fsm_r == S_FIN && (!out_valid_r || out_ch.ready)) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.steer_angle = out_steer_r;
  assign out_ch.speed_cmd = out_speed_r;
  assign out_ch.near_index = out_near_r;
  assign out_ch.status = out_status_r;

  a_count_rng: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(PATH_DEPTH)) else $error("point count beyond depth");
  a_cor_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (fsm_r == S_ANGW || fsm_r == S_AT1W || fsm_r == S_SCW || fsm_r == S_DW))
    else $error("cordic result with no one waiting");
  a_scan_rng: assert property (@(posedge clk) disable iff (!rst_n)
    fsm_r == S_B0 |-> k_r < count_r) else $error("forward scan past the last point");
endmodule

>>> tb/pure_pursuit_steering_tb.sv
`timescale 1ns / 1ps
module pure_pursuit_steering_tb;
  import pps_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_CYCLES = 2500;
  localparam int ITEM_TARGET = 140;

  typedef struct {
    logic [ACT_W-1:0] action;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] pose_x;
    logic signed [23:0] pose_y;
    logic signed [15:0] heading;
  } steer_item_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic [SPD_W-1:0] speed_cmd;
    logic [NEAR_W-1:0] near_index;
    logic [STAT_W-1:0] status;
  } steer_res_t;

  class steer_scoreboard;
    longint east[DEPTH];
    longint north[DEPTH];
    int count;
    longint unsigned wheelbase, lookahead, speed;
    longint atan_q16[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
    steer_res_t expected_q[$];
    int errors;

    function void restart();
      count = 0;
      wheelbase = 768;
      lookahead = 1152;
      speed = 1500;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WHEELBASE: wheelbase = val;
        REG_LOOKAHEAD: lookahead = val;
        REG_SPEED: speed = val;
        default: ;
      endcase
    endfunction

    function void add_expected(steer_res_t r);
      expected_q = {expected_q, r};
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(-v) : v;
    endfunction

    function longint unsigned sq_sat(longint unsigned a);
      return a > 64'hFFFF_FFFF ? '1 : a * a;
    endfunction

    function longint unsigned add_sat(longint unsigned a, longint unsigned b);
      return a > ~b ? '1 : a + b;
    endfunction

    function void rotate(input longint zin, output longint c, output longint s);
      longint x, y, z, nx, ny;
      bit flip;
      x = Q_GAIN;
      y = 0;
      flip = 0;
      z = zin % A_TWO_PI;
      if (z > A_PI) z -= A_TWO_PI;
      if (z < -A_PI) z += A_TWO_PI;
      if (z > A_HALF_PI) begin
        z -= A_PI;
        flip = 1;
      end else if (z < -A_HALF_PI) begin
        z += A_PI;
        flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (z >= 0) begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q16[i];
        end else begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q16[i];
        end
        x = nx;
        y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    // vectoring mode, x must not be negative
    function longint vector_angle(longint y, longint x);
      longint z, nx, ny;
      z = 0;
      if (y == 0) return 0;
      for (int i = 0; i < 16; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i); ny = y - (x >>> i); z += atan_q16[i];
        end else begin
          nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_q16[i];
        end
        x = nx;
        y = ny;
      end
      return z;
    endfunction

    function void body_frame(input int k, input longint px, input longint py,
                             input longint c, input longint s,
                             output longint lx, output longint ly);
      longint dx, dy;
      dx = east[k] - px;
      dy = north[k] - py;
      lx = (c * dx + s * dy + (longint'(1) << 23)) >>> 24;
      ly = (c * dy - s * dx + (longint'(1) << 23)) >>> 24;
    endfunction

    function void note(steer_item_t it);
      steer_res_t r;
      longint px, py, c, s, lx, ly, th, ct, st, delta;
      longint unsigned best, d2, l2;
      int near;
      bit found;
      case (it.action)
        ACT_APPEND: begin
          if (count < DEPTH) begin
            east[count] = it.point_x;
            north[count] = it.point_y;
            count++;
          end
          return;
        end
        ACT_CLEAR: begin
          count = 0;
          return;
        end
        ACT_POSE: ;
        default: return;
      endcase
      r = '0;
      if (count == 0) begin
        r.status = ST_EMPTY;
        add_expected(r);
        return;
      end
      px = it.pose_x;
      py = it.pose_y;
      best = '1;
      near = 0;
      for (int k = 0; k < count; k++) begin
        d2 = add_sat(sq_sat(mag(east[k] - px)), sq_sat(mag(north[k] - py)));
        if (k == 0 || d2 < best) begin
          best = d2;
          near = k;
        end
      end
      r.near_index = near[NEAR_W-1:0];
      rotate(longint'(it.heading) * 8, c, s);
      l2 = sq_sat(lookahead);
      found = 0;
      for (int k = near; k < count && !found; k++) begin
        body_frame(k, px, py, c, s, lx, ly);
        if (lx > 0 && add_sat(sq_sat(mag(lx)), sq_sat(mag(ly))) >= l2) found = 1;
      end
      if (!found) begin
        body_frame(count - 1, px, py, c, s, lx, ly);
        found = lx > 0;
      end
      if (!found) begin
        r.status = ST_NOFWD;
        add_expected(r);
        return;
      end
      th = vector_angle(ly, lx);
      rotate(th, ct, st);
      delta = vector_angle(2 * longint'(wheelbase) * st, longint'(lookahead) << 24);
      r.steer_angle = 16'((delta + 4) >>> 3);
      r.speed_cmd = SPD_W'(speed);
      r.status = ST_TRACK;
      add_expected(r);
    endfunction

    function void check(steer_res_t got);
      steer_res_t exp_r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.steer_angle !== exp_r.steer_angle) begin
        $display("%0t: steer_angle expected %0d actual %0d", $time,
                 exp_r.steer_angle, got.steer_angle);
        errors++;
      end
      if (got.speed_cmd !== exp_r.speed_cmd) begin
        $display("%0t: speed_cmd expected %0d actual %0d", $time,
                 exp_r.speed_cmd, got.speed_cmd);
        errors++;
      end
      if (got.near_index !== exp_r.near_index) begin
        $display("%0t: near_index expected %0d actual %0d", $time,
                 exp_r.near_index, got.near_index);
        errors++;
      end
      if (got.status !== exp_r.status) begin
        $display("%0t: status expected %0d actual %0d", $time,
                 exp_r.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_WHEELBASE;
  logic [CFG_W-1:0] cfg_data = '0;
  bit idle_on = 1;
  bit hold_req = 0;
  bit hold_done = 0;
  int items_sent = 0;
  steer_scoreboard sb;

  pps_in_if in_ch ();
  pps_out_if out_ch ();

  pure_pursuit_steering DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  task automatic send(steer_item_t it);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 0;
    end
    @(negedge clk);
    in_ch.action = it.action;
    in_ch.point_x = it.point_x;
    in_ch.point_y = it.point_y;
    in_ch.pose_x = it.pose_x;
    in_ch.pose_y = it.pose_y;
    in_ch.heading = it.heading;
    in_ch.valid = 1;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(it);
    if (it.action != ACT_NONE) items_sent++;
  endtask

  task automatic send_point(int x, int y);
    steer_item_t it;
    it = '{ACT_APPEND, x, y, $urandom, $urandom, $urandom};
    send(it);
  endtask

  task automatic send_pose(int x, int y, int h);
    steer_item_t it;
    it = '{ACT_POSE, $urandom, $urandom, x, y, h};
    send(it);
  endtask

  task automatic send_clear();
    steer_item_t it;
    it = '{ACT_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom};
    send(it);
  endtask

  // wait for every result, then let a trailing append settle
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_ch.valid = 0;
    cfg_we = 1;
    cfg_idx = idx;
    cfg_data = val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_regs(logic [15:0] wb, logic [15:0] la, logic [15:0] sp);
    write_reg(REG_WHEELBASE, wb);
    write_reg(REG_LOOKAHEAD, la);
    write_reg(REG_SPEED, sp);
  endtask

  // a path along a heading and poses near its start, or raw noise
  task automatic random_burst();
    steer_item_t it;
    int h, n, stp, bx, by;
    real a;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(2, 6)) begin
        it = '{$urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom, $urandom};
        send(it);
      end
      return;
    end
    h = $urandom_range(0, 51472) - 25736;
    a = h / 8192.0;
    n = $urandom_range(2, 12);
    stp = $urandom_range(100, 600);
    bx = $urandom_range(0, 2097152) - 1048576;
    by = $urandom_range(0, 2097152) - 1048576;
    if ($urandom_range(0, 1)) send_clear();
    for (int k = 0; k < n; k++)
      send_point(bx + $rtoi(k * stp * $cos(a)) + $urandom_range(0, 40) - 20,
                 by + $rtoi(k * stp * $sin(a)) + $urandom_range(0, 40) - 20);
    repeat ($urandom_range(1, 3))
      send_pose(bx + $urandom_range(0, 400) - 200, by + $urandom_range(0, 400) - 200,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) - 32768
                                            : h + $urandom_range(0, 4000) - 2000);
  endtask

  initial begin
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ch.ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ch.ready = 0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ch.ready = 1;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check('{out_ch.steer_angle, out_ch.speed_cmd, out_ch.near_index, out_ch.status});
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    sb.restart();
    in_ch.valid = 0;
    in_ch.action = ACT_APPEND;
    in_ch.point_x = '0;
    in_ch.point_y = '0;
    in_ch.pose_x = '0;
    in_ch.pose_y = '0;
    in_ch.heading = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed
    send_pose(0, 0, 0);
    send('{ACT_NONE, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF});
    send_point(8388607, 8388607);
    send_point(-8388608, -8388608);
    send_pose(8388607, -8388608, 25736);
    send_pose(-8388608, 8388607, -25736);
    send_clear();
    for (int k = 0; k < 8; k++) send_point(k * 300, 0);
    send_point(600, 0);
    send_pose(0, 0, 0);
    send_pose(600, 10, 0);
    send_pose(0, 0, 25736);
    send_pose(0, 0, -32768);
    send_pose(0, 0, 32767);
    send_pose(2100, 0, 0);
    drain();
    set_regs(16'd0, 16'd0, 16'd0);
    send_pose(0, 5, 0);
    send_pose(0, -5, 0);
    send_pose(0, 0, 0);
    drain();
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pose(0, 0, 0);
    send_pose(0, 300, 4000);
    drain();

    // random phases through several register settings
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: set_regs(16'd0, 16'd0, 16'd0);
        1: set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: set_regs($urandom_range(0, 2000), $urandom_range(0, 3000), $urandom);
      endcase
      repeat (2) random_burst();
      if (!hold_done && items_sent > 60) begin
        @(negedge clk);
        in_ch.valid = 0;
        hold_req = 1;
        hold_done = 1;
        repeat (2) random_burst();
      end
      if (items_sent > ITEM_TARGET - 30) idle_on = 0;
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
